// ===== hdl/bis_pkg.sv =====
// package for the bicubic image scaler: sizes, register indexes, beat types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bis_pkg;
    localparam int MAX_SRC_WIDTH  = 256;
    localparam int MAX_SRC_HEIGHT = 256;
    localparam int MAX_CHANNELS   = 4;
    localparam int XW = $clog2(MAX_SRC_WIDTH);
    localparam int YW = $clog2(MAX_SRC_HEIGHT);
    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int AW = XW + YW + CW;
    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT * MAX_CHANNELS;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 25;
    // accumulator width for Q16 kernel values
    localparam int VW = 40;

    typedef enum logic [CFG_IW-1:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_CHANNELS   = 3'd2,
        REG_DST_WIDTH  = 3'd3,
        REG_DST_HEIGHT = 3'd4,
        REG_X_STEP     = 3'd5,
        REG_Y_STEP     = 3'd6
    } t_reg_idx;

    localparam logic OP_STORE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [9:0]  x_coord;
        logic [9:0]  y_coord;
        logic [1:0]  channel;
        logic [7:0]  sample_value;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] pixel_value;
    } t_out_beat;
endpackage
`default_nettype wire

// ===== hdl/bis_stream_if.sv =====
// valid/ready channel carrying one payload type
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface bis_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/bicubic_image_scaler.sv =====
// bicubic image scaler top level: frame store, sequencer, shared mac unit
// depends on bis_pkg and bis_stream_if
`timescale 1ns / 1ps
`default_nettype none
// A store beat writes the frame store when its position and channel are in
// range and returns to idle; a compute on a channel at or above the channel
// count returns a zero pixel. No new beat is taken while one is in progress.
// The position multiplies, x then y, run on the shared multiplier. Each of
// the four row passes reads the frame store (one read port, registered
// data), builds the coefficients, runs three dependent multiply steps and
// ends with the halving and the center add. The column pass picks up the
// row results instead of reading. The result sits in an output register,
// and the next beat is taken in the cycle that hands it over.
// The frame store has no clearing pass; unwritten entries read undefined.
// The destination size registers are accepted but have no effect.
module bicubic_image_scaler (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [bis_pkg::CFG_IW-1:0] i_cfg_idx,
    input  wire logic [bis_pkg::CFG_DW-1:0] i_cfg_data,
    bis_stream_if.sink                 i_in,
    bis_stream_if.source               o_out
);
    import bis_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_POSX  = 8'b00000010,
        S_POSY  = 8'b00000100,
        S_READ  = 8'b00001000,
        S_COEF  = 8'b00010000,
        S_MAC   = 8'b00100000,
        S_FIN   = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    // configuration registers
    logic [8:0]  r_src_w, r_src_h;
    logic [2:0]  r_chan;
    logic [24:0] r_xstep, r_ystep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= 9'd256; r_src_h <= 9'd256; r_chan <= 3'd1;
            r_xstep <= 25'd32768; r_ystep <= 25'd32768;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SRC_WIDTH:  r_src_w <= i_cfg_data[8:0];
                REG_SRC_HEIGHT: r_src_h <= i_cfg_data[8:0];
                REG_CHANNELS:   r_chan  <= i_cfg_data[2:0];
                REG_DST_WIDTH, REG_DST_HEIGHT: ;
                REG_X_STEP:     r_xstep <= i_cfg_data;
                REG_Y_STEP:     r_ystep <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective sizes, clamped to 1..max
    logic [12:0] w_eff, h_eff;
    logic [2:0]  nch;
    always_comb begin
        w_eff = (r_src_w == 9'd0) ? 13'd1 :
                ({4'd0, r_src_w} > 13'(MAX_SRC_WIDTH)) ? 13'(MAX_SRC_WIDTH) : {4'd0, r_src_w};
        h_eff = (r_src_h == 9'd0) ? 13'd1 :
                ({4'd0, r_src_h} > 13'(MAX_SRC_HEIGHT)) ? 13'(MAX_SRC_HEIGHT) : {4'd0, r_src_h};
        nch   = (r_chan == 3'd0) ? 3'd1 :
                (r_chan > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : r_chan;
    end

    t_state r_state;
    t_in_beat r_in;
    logic [7:0] r_result;

    // frame store, one write port and one read port
    logic [7:0] mem [DEPTH];
    logic [7:0] r_rd;
    logic       mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= r_in.sample_value;
        r_rd <= mem[mem_ra];
    end

    // shared multiplier: signed 40 x 18
    logic signed [VW-1:0] mul_a;
    logic signed [17:0]   mul_b;
    logic signed [VW+17:0] r_prod;
    always_ff @(posedge i_clk) r_prod <= mul_a * mul_b;

    // position and neighbourhood
    logic [18:0] r_ix, r_iy;
    logic [15:0] r_tx, r_ty;
    logic [2:0]  r_row;         // 0..3 rows, 4 column pass
    logic [2:0]  r_k;           // read / mac step
    logic [1:0]  r_ph;          // multiply pipeline phase
    logic signed [VW-1:0] r_s [4];
    logic signed [VW-1:0] r_rows [4];
    logic signed [VW-1:0] r_a2, r_b2, r_c2, r_acc;

    // clamped neighbour index
    function automatic logic [12:0] clampi(input logic [18:0] base, input logic [1:0] k,
                                           input logic [12:0] n);
        logic signed [20:0] v;
        begin
            v = $signed({2'b00, base}) + $signed({19'd0, k}) - 21'sd1;
            if (v < 0) clampi = 13'd0;
            else if (v >= $signed({8'd0, n})) clampi = n - 13'd1;
            else clampi = v[12:0];
        end
    endfunction

    logic [12:0] sx, sy;
    always_comb begin
        sx = clampi(r_ix, r_k[1:0], w_eff);
        sy = clampi(r_iy, r_row[1:0], h_eff);
        mem_ra = {sy[YW-1:0], sx[XW-1:0], r_in.channel[CW-1:0]};
        mem_wa = {r_in.y_coord[YW-1:0], r_in.x_coord[XW-1:0], r_in.channel[CW-1:0]};
    end

    // floor shift of a product by 16
    logic signed [VW-1:0] prod_sh;
    assign prod_sh = VW'(r_prod >>> 16);

    // multiplier operands: step times coordinate, then kernel steps
    always_comb begin
        mul_a = '0; mul_b = '0;
        case (r_state)
            S_POSX: begin
                mul_a = VW'(r_xstep);
                mul_b = $signed({8'd0, r_in.x_coord});
            end
            S_POSY: begin
                mul_a = VW'(r_ystep);
                mul_b = $signed({8'd0, r_in.y_coord});
            end
            S_MAC: begin
                mul_a = (r_k == 3'd0) ? r_a2 : r_acc;
                mul_b = (r_row == 3'd4) ? $signed({2'b00, r_ty}) : $signed({2'b00, r_tx});
            end
            default: ;
        endcase
    end

    logic store_ok;
    assign store_ok = ({22'd0, r_in.x_coord} < 32'(MAX_SRC_WIDTH)) &&
                      ({22'd0, r_in.y_coord} < 32'(MAX_SRC_HEIGHT)) &&
                      ({1'b0, r_in.channel} < nch);

    logic signed [VW-1:0] ka, kb, kc, kd;
    assign ka = r_s[0]; assign kb = r_s[1]; assign kc = r_s[2]; assign kd = r_s[3];

    // halving plus center sample ends a pass
    logic signed [VW-1:0] fin_v;
    assign fin_v = (r_acc >>> 1) + kb;

    assign i_in.ready  = (r_state == S_IDLE) || ((r_state == S_OUT) && o_out.ready);
    assign o_out.valid = (r_state == S_OUT);
    assign o_out.data.pixel_value = r_result;
    assign mem_we = (r_state == S_POSX) && (r_in.operation == OP_STORE) && store_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph <= '0; r_k <= '0; r_row <= '0;
        end else begin
            case (r_state)
                S_IDLE, S_OUT: begin
                    if (i_in.valid && i_in.ready) begin
                        r_in <= i_in.data;
                        r_state <= S_POSX;
                        r_ph <= 2'd0;
                    end else if (r_state == S_OUT && o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                S_POSX: begin
                    // store ends here; in-range compute issues x multiply
                    if (r_in.operation == OP_STORE) begin
                        r_state <= S_IDLE;
                    end else if ({1'b0, r_in.channel} >= nch) begin
                        r_result <= 8'd0;
                        r_state <= S_OUT;
                    end else begin
                        r_ph <= 2'd1;
                        r_state <= S_POSY;
                    end
                end
                S_POSY: begin
                    // x product lands first, then the y product
                    if (r_ph == 2'd1) begin
                        r_ix <= r_prod[34:16]; r_tx <= r_prod[15:0];
                        r_ph <= 2'd0;
                    end else begin
                        r_iy <= r_prod[34:16]; r_ty <= r_prod[15:0];
                        r_row <= 3'd0; r_k <= 3'd0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    // address for step k issued, data for k-1 lands
                    if (r_row == 3'd4) begin
                        r_s[0] <= r_rows[0]; r_s[1] <= r_rows[1];
                        r_s[2] <= r_rows[2]; r_s[3] <= r_rows[3];
                        r_state <= S_COEF;
                    end else begin
                        if (r_k != 3'd0) r_s[r_k[1:0] - 2'd1] <= VW'({r_rd, 16'd0});
                        if (r_k == 3'd4) r_state <= S_COEF;
                        else r_k <= r_k + 3'd1;
                    end
                end
                S_COEF: begin
                    r_a2 <= -ka + 3 * kb - 3 * kc + kd;
                    r_b2 <= 2 * ka - 5 * kb + 4 * kc - kd;
                    r_c2 <= kc - ka;
                    r_k <= 3'd0; r_ph <= 2'd0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    // phase 0 issues multiply, phase 1 takes the product
                    if (r_ph == 2'd0) r_ph <= 2'd1;
                    else begin
                        r_ph <= 2'd0;
                        case (r_k)
                            3'd0: r_acc <= prod_sh + r_b2;
                            3'd1: r_acc <= prod_sh + r_c2;
                            default: r_acc <= prod_sh;
                        endcase
                        if (r_k == 3'd2) r_state <= S_FIN;
                        else r_k <= r_k + 3'd1;
                    end
                end
                S_FIN: begin
                    if (r_row == 3'd4) begin
                        if (fin_v < 0) r_result <= 8'd0;
                        else if (fin_v[VW-1:16] > 255) r_result <= 8'd255;
                        else r_result <= fin_v[23:16];
                        r_state <= S_OUT;
                    end else begin
                        r_rows[r_row[1:0]] <= fin_v;
                        r_row <= r_row + 3'd1;
                        r_k <= 3'd0;
                        r_state <= S_READ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// testbench for the bicubic image scaler: fills small source images, then checks
// resampled pixels against a built-in bicubic predictor
// depends on bis_pkg, bis_stream_if and bicubic_image_scaler
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import bis_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IW-1:0] i_cfg_idx = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;

    bis_stream_if #(.T(t_in_beat)) in_if ();
    bis_stream_if #(.T(t_out_beat)) out_if ();

    bicubic_image_scaler uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in(in_if.sink), .o_out(out_if.source)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the block's registers and frame store
    logic [8:0]  sh_src_w, sh_src_h;
    logic [2:0]  sh_chans;
    logic [10:0] sh_dst_w, sh_dst_h;
    logic [24:0] sh_x_step, sh_y_step;
    logic [7:0]  pix_mem [DEPTH];
    bit          pix_written [DEPTH];

    logic [7:0] pixel_queue[$];
    int         n_errors = 0;
    int         src_idle_pct = 0;
    int         snk_idle_pct = 0;
    int         quiet_cycles = 0;
    bit         in_accepted = 1'b0;

    initial begin
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
    end

    function automatic int eff_dim(int v, int hi);
        if (v < 1) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int clamp_index(longint v, int n);
        if (v < 0) return 0;
        return (v >= n) ? n - 1 : int'(v);
    endfunction

    function automatic int store_addr(int x, int y, int c);
        return ((y * MAX_SRC_WIDTH) + x) * MAX_CHANNELS + c;
    endfunction

    // catmull-rom segment in q16, floors on every shift
    function automatic longint cubic_q16(longint a, longint b, longint c, longint d,
                                         longint t);
        longint a2, b2, c2, acc;
        a2 = -a + 3 * b - 3 * c + d;
        b2 = 2 * a - 5 * b + 4 * c - d;
        c2 = c - a;
        acc = ((a2 * t) >>> 16) + b2;
        acc = ((acc * t) >>> 16) + c2;
        acc = (acc * t) >>> 16;
        return (acc >>> 1) + b;
    endfunction

    // true when the channel is out of range or every neighborhood tap of a compute has been written
    function automatic bit taps_written(int xc, int yc, int ch);
        longint px, py;
        int w, h;
        px = longint'(xc) * sh_x_step;
        py = longint'(yc) * sh_y_step;
        w = eff_dim(sh_src_w, MAX_SRC_WIDTH);
        h = eff_dim(sh_src_h, MAX_SRC_HEIGHT);
        if (ch >= eff_dim(sh_chans, MAX_CHANNELS)) return 1'b1;
        for (int ky = 0; ky < 4; ky++)
            for (int kx = 0; kx < 4; kx++)
                if (!pix_written[store_addr(clamp_index((px >> 16) + kx - 1, w),
                                            clamp_index((py >> 16) + ky - 1, h), ch)])
                    return 1'b0;
        return 1'b1;
    endfunction

    // apply one beat to the shadow state and queue the pixel it yields
    task automatic predict_pixel(input t_in_beat b);
        longint px, py, tx, ty, res;
        longint row_q16 [4];
        longint s [4];
        int w, h, nch, ix, iy;
        w = eff_dim(sh_src_w, MAX_SRC_WIDTH);
        h = eff_dim(sh_src_h, MAX_SRC_HEIGHT);
        nch = eff_dim(sh_chans, MAX_CHANNELS);
        if (b.operation == OP_STORE) begin
            if (b.x_coord < MAX_SRC_WIDTH && b.y_coord < MAX_SRC_HEIGHT && b.channel < nch) begin
                pix_mem[store_addr(b.x_coord, b.y_coord, b.channel)] = b.sample_value;
                pix_written[store_addr(b.x_coord, b.y_coord, b.channel)] = 1'b1;
            end
            return;
        end
        if (b.channel >= nch) begin
            pixel_queue.push_back(8'd0);
            return;
        end
        px = longint'(b.x_coord) * sh_x_step;
        py = longint'(b.y_coord) * sh_y_step;
        tx = px & 64'hFFFF;
        ty = py & 64'hFFFF;
        for (int ky = 0; ky < 4; ky++) begin
            iy = clamp_index((py >> 16) + ky - 1, h);
            for (int kx = 0; kx < 4; kx++) begin
                ix = clamp_index((px >> 16) + kx - 1, w);
                s[kx] = longint'(pix_mem[store_addr(ix, iy, b.channel)]) << 16;
            end
            row_q16[ky] = cubic_q16(s[0], s[1], s[2], s[3], tx);
        end
        res = cubic_q16(row_q16[0], row_q16[1], row_q16[2], row_q16[3], ty);
        if (res < 0) res = 0;
        res = res >>> 16;
        if (res > 255) res = 255;
        pixel_queue.push_back(res[7:0]);
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        n_errors++;
    endtask

    // send one beat, honoring the sender idle rate
    task automatic send_beat(input t_in_beat b);
        bit rdy;
        if ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data <= b;
        do begin
            @(negedge i_clk);
            rdy = in_if.ready;
            @(posedge i_clk);
        end while (!rdy);
        in_accepted = 1'b1;
        predict_pixel(b);
    endtask

    task automatic send_store(input int x, input int y, input int c, input int v);
        t_in_beat b;
        b.operation = OP_STORE;
        b.x_coord = 10'(x);
        b.y_coord = 10'(y);
        b.channel = 2'(c);
        b.sample_value = 8'(v);
        send_beat(b);
    endtask

    // computes that would read unwritten taps are skipped
    task automatic send_compute(input int x, input int y, input int c);
        t_in_beat b;
        if (!taps_written(x, y, c)) return;
        b.operation = OP_COMPUTE;
        b.x_coord = 10'(x);
        b.y_coord = 10'(y);
        b.channel = 2'(c);
        b.sample_value = 8'($urandom_range(255));
        send_beat(b);
    endtask

    // wait until the block is idle, then write one register
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DW-1:0] val);
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pixel_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_SRC_WIDTH:  sh_src_w = val[8:0];
            REG_SRC_HEIGHT: sh_src_h = val[8:0];
            REG_CHANNELS:   sh_chans = val[2:0];
            REG_DST_WIDTH:  sh_dst_w = val[10:0];
            REG_DST_HEIGHT: sh_dst_h = val[10:0];
            REG_X_STEP:     sh_x_step = val[24:0];
            REG_Y_STEP:     sh_y_step = val[24:0];
            default: ;
        endcase
    endtask

    task automatic setup_image(input int w, input int h, input int nch,
                               input logic [24:0] xs, input logic [24:0] ys);
        write_reg(REG_SRC_WIDTH, CFG_DW'(w));
        write_reg(REG_SRC_HEIGHT, CFG_DW'(h));
        write_reg(REG_CHANNELS, CFG_DW'(nch));
        write_reg(REG_DST_WIDTH, CFG_DW'($urandom_range(0, 2047)));
        write_reg(REG_DST_HEIGHT, CFG_DW'($urandom_range(0, 2047)));
        write_reg(REG_X_STEP, xs);
        write_reg(REG_Y_STEP, ys);
    endtask

    // fill the active area, values at random or 0/255 extremes
    task automatic fill_image(input bit extremes);
        int w, h, nch;
        w = eff_dim(sh_src_w, MAX_SRC_WIDTH);
        h = eff_dim(sh_src_h, MAX_SRC_HEIGHT);
        nch = eff_dim(sh_chans, MAX_CHANNELS);
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                for (int c = 0; c < nch; c++)
                    send_store(x, y, c, extremes ? (((x + y) % 2) ? 255 : 0)
                                                 : $urandom_range(255));
    endtask

    function automatic logic [24:0] pick_step();
        case ($urandom_range(9))
            0: return 25'd0;
            1: return 25'h1FFFFFF;
            2: return 25'h10000;
            default: return 25'($urandom_range(0, 25'h3FFFF));
        endcase
    endfunction

    // small checkerboard image with all channels, edge and extreme cases
    task automatic test_directed();
        setup_image(4, 4, 4, 25'h8000, 25'h8000);
        fill_image(1'b1);
        send_store(1023, 0, 0, 8'hAA);
        send_store(0, 1023, 0, 8'h55);
        send_compute(0, 0, 0);
        send_compute(1, 1, 3);
        send_compute(3, 5, 1);
        send_compute(1023, 1023, 2);
        write_reg(REG_CHANNELS, 25'd2);
        send_store(0, 0, 3, 8'h12);
        send_compute(1, 1, 3);
        send_compute(2, 2, 1);
        write_reg(REG_CHANNELS, 25'd0);
        send_compute(1, 2, 0);
        send_compute(1, 2, 1);
        write_reg(REG_X_STEP, 25'h1FFFFFF);
        write_reg(REG_Y_STEP, 25'd0);
        send_compute(1023, 7, 0);
        send_compute(1, 0, 0);
    endtask

    // one full-width row: width above the limit clamps, height zero clamps to one
    task automatic test_wide_row();
        setup_image(511, 0, 1, 25'h3A5C3, 25'h1234);
        fill_image(1'b0);
        for (int i = 0; i < 40; i++)
            send_compute($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(3));
    endtask

    // random small images, mix of computes, rewrites and out-of-range stores
    task automatic test_random_mix(input int n_items);
        int w, h, nch;
        setup_image($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(0, 7),
                    pick_step(), pick_step());
        fill_image(1'b0);
        w = eff_dim(sh_src_w, MAX_SRC_WIDTH);
        h = eff_dim(sh_src_h, MAX_SRC_HEIGHT);
        for (int i = 0; i < n_items; i++) begin
            case ($urandom_range(9))
                0, 1, 2:
                    send_store($urandom_range(w - 1), $urandom_range(h - 1),
                               $urandom_range(3), $urandom_range(255));
                3:
                    send_store($urandom_range(1023), $urandom_range(1023),
                               $urandom_range(3), $urandom_range(255));
                default:
                    if ($urandom_range(3) == 0)
                        send_compute($urandom_range(1023), $urandom_range(1023),
                                     $urandom_range(3));
                    else
                        send_compute($urandom_range(15), $urandom_range(15),
                                     $urandom_range(3));
            endcase
        end
    endtask

    // receiver stalls
    always @(posedge i_clk)
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            in_accepted = 1'b1;
            if (pixel_queue.size() == 0)
                report_mismatch($sformatf("unexpected pixel %0d", out_if.data.pixel_value));
            else if (out_if.data.pixel_value !== pixel_queue[0])
                report_mismatch($sformatf("pixel_value got %0d want %0d",
                                          out_if.data.pixel_value, pixel_queue[0]));
            if (pixel_queue.size() != 0) void'(pixel_queue.pop_front());
        end
    end

    // watchdog on cycles with no beat moving
    always @(negedge i_clk) begin
        quiet_cycles = in_accepted ? 0 : quiet_cycles + 1;
        in_accepted = 1'b0;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        sh_src_w = 256;
        sh_src_h = 256;
        sh_chans = 1;
        sh_dst_w = 512;
        sh_dst_h = 512;
        sh_x_step = 32768;
        sh_y_step = 32768;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        src_idle_pct = 21;
        snk_idle_pct = 61;
        test_wide_row();
        test_random_mix(80);
        src_idle_pct = 61;
        snk_idle_pct = 21;
        test_random_mix(80);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_mix(80);

        in_if.valid <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/bis_pkg.sv
hdl/bis_stream_if.sv
hdl/bicubic_image_scaler.sv
dv/tb.sv
